// ----- rtl/ccf_pkg.sv -----
// Shared types, codes and fixed-point helpers of the cubic curve fit core.
package ccf_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_FIT_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_START_VALUE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_START_SLOPE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_START_ACCEL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_END_VALUE   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SPAN_LENGTH = 3'd5;

  // Derivative order codes
  localparam logic [2:0] ORD_VALUE = 3'd0;
  localparam logic [2:0] ORD_SLOPE = 3'd1;
  localparam logic [2:0] ORD_ACCEL = 3'd2;
  localparam logic [2:0] ORD_JERK  = 3'd3;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [67:0] S68_MAX = 68'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [67:0] S68_MIN = 68'shF_8000_0000_0000_0000;

  // Item traveling down the evaluation pipeline
  typedef struct packed {
    logic [2:0]         order;
    logic [31:0]        pmag;
    logic               pneg;
    logic signed [63:0] acc;
    logic               sat;
    logic               zero;
    logic               inv;
  } evl_t;

  // Coefficient set handed from the fit sequencer to the evaluator
  typedef struct packed {
    logic signed [63:0] c0;
    logic signed [63:0] c1;
    logic signed [63:0] c2;
    logic signed [63:0] c3;
    logic signed [63:0] c2x2;
    logic signed [63:0] c3x3;
    logic signed [63:0] c3x6;
    logic               sat;
    logic               sat2x;
    logic               sat3x;
    logic               sat6x;
  } coef_t;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } sval_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] mag;
  } umag_t;

  // Clamp a wide signed value to the 64-bit range
  function automatic sval_t clamp64(logic signed [67:0] x);
    sval_t r;
    r.sat = 1'b0;
    r.val = x[63:0];
    if (x > S68_MAX) begin
      r.sat = 1'b1;
      r.val = S64_MAX;
    end else if (x < S68_MIN) begin
      r.sat = 1'b1;
      r.val = S64_MIN;
    end
    return r;
  endfunction

  // Saturating add of two 64-bit values
  function automatic sval_t sadd64(logic signed [63:0] a, logic signed [63:0] b);
    return clamp64(68'(a) + 68'(b));
  endfunction

  // Saturating add of b and a sign-magnitude value (magnitude at most 2^63-1)
  function automatic sval_t sadd_sm(logic signed [63:0] b, logic [63:0] mag, logic neg);
    logic signed [67:0] m;
    m = $signed({4'b0000, mag});
    return clamp64(neg ? 68'(b) - m : 68'(b) + m);
  endfunction

  // Finish of the fixed-point product from its two 32-bit partial products
  function automatic umag_t mulq_fin(logic [63:0] tlo, logic [63:0] thi, int unsigned frac);
    umag_t       r;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [64:0] sum;
    lo    = (tlo + (64'd1 << (frac - 1))) >> frac;
    hi    = thi << (32 - frac);
    sum   = {1'b0, hi} + {1'b0, lo};
    r.sat = 1'b0;
    r.mag = sum[63:0];
    if ((thi > (64'h7FFF_FFFF_FFFF_FFFF >> (32 - frac))) || sum[64] || sum[63]) begin
      r.sat = 1'b1;
      r.mag = 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] signed_of(logic [63:0] mag, logic neg);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ----- rtl/cubic_curve_fit_and_evaluate_core.sv -----
// Throughput: one beat per cycle through the Horner pipeline (three 4-stage steps)
// while the output is not stalled and no fit pass runs. After a register write
// s_axis_tready stays low while the fit sequencer rebuilds the coefficients
// (mode 1: six bit-serial divisions). Reset (rst_ni low, asynchronous) loads the
// register reset values and zero coefficients; the pipeline comes up empty and
// no fit pass is needed.
module cubic_curve_fit_and_evaluate_core import ccf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [31:0] position
  input  logic [2:0]          s_axis_tuser,   // [2:0] deriv_order
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // [31:0] result_value
  output logic [1:0]          m_axis_tuser    // [0] saturated, [1] invalid_span
);

  localparam logic [63:0] Half = 64'd1 << (FRAC_BITS - 1);

  logic               fit_mode_q;
  logic signed [31:0] start_value_q, start_slope_q, start_accel_q, end_value_q;
  logic signed [31:0] span_length_q;
  logic               cfg_hit;
  logic               busy;
  coef_t              coef;
  logic               en;

  // Configuration registers
  always_comb begin
    unique case (cfg_idx_i)
      REG_FIT_MODE, REG_START_VALUE, REG_START_SLOPE,
      REG_START_ACCEL, REG_END_VALUE, REG_SPAN_LENGTH: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= 1'b0;
      start_value_q <= '0;
      start_slope_q <= '0;
      start_accel_q <= '0;
      end_value_q   <= '0;
      span_length_q <= 32'sd1 <<< FRAC_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIT_MODE:    fit_mode_q    <= cfg_wdata_i[0];
        REG_START_VALUE: start_value_q <= cfg_wdata_i;
        REG_START_SLOPE: start_slope_q <= cfg_wdata_i;
        REG_START_ACCEL: start_accel_q <= cfg_wdata_i;
        REG_END_VALUE:   end_value_q   <= cfg_wdata_i;
        REG_SPAN_LENGTH: span_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ccf_derive #(.FRAC_BITS(FRAC_BITS)) u_derive (
    .clk_i,
    .rst_ni,
    .start_i       (cfg_hit),
    .fit_mode_i    (fit_mode_q),
    .start_value_i (start_value_q),
    .start_slope_i (start_slope_q),
    .start_accel_i (start_accel_q),
    .end_value_i   (end_value_q),
    .span_length_i (span_length_q),
    .busy_o        (busy),
    .coef_o        (coef)
  );

  // Whole pipeline moves when the output register is free or drained
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !busy;

  // Stage 0: operand prep and start value per order
  logic               vld0_q;
  evl_t               item0_q, item0_d;
  logic signed [31:0] pos;

  assign pos = s_axis_tdata;

  always_comb begin
    item0_d.order = s_axis_tuser;
    item0_d.pmag  = pos[31] ? 32'(-pos) : 32'(pos);
    item0_d.pneg  = pos[31];
    item0_d.inv   = (span_length_q < 32'sd1);
    item0_d.zero  = item0_d.inv || (s_axis_tuser > ORD_JERK);
    unique case (s_axis_tuser)
      ORD_VALUE: begin
        item0_d.acc = coef.c3;
        item0_d.sat = coef.sat;
      end
      ORD_SLOPE: begin
        item0_d.acc = coef.c3x3;
        item0_d.sat = coef.sat | coef.sat3x | coef.sat2x;
      end
      ORD_ACCEL: begin
        item0_d.acc = coef.c3x6;
        item0_d.sat = coef.sat | coef.sat6x | coef.sat2x;
      end
      default: begin
        item0_d.acc = coef.c3x6;
        item0_d.sat = coef.sat | coef.sat6x;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= s_axis_tvalid && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) item0_q <= item0_d;
  end

  // Horner steps
  logic vld1, vld2, vld3;
  evl_t item1, item2, item3;

  ccf_horner_step #(.FRAC_BITS(FRAC_BITS), .STEP(3'd1)) u_step1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld0_q), .item_i(item0_q),
    .coef_i(coef), .vld_o(vld1), .item_o(item1)
  );

  ccf_horner_step #(.FRAC_BITS(FRAC_BITS), .STEP(3'd2)) u_step2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld1), .item_i(item1),
    .coef_i(coef), .vld_o(vld2), .item_o(item2)
  );

  ccf_horner_step #(.FRAC_BITS(FRAC_BITS), .STEP(3'd3)) u_step3 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld2), .item_i(item2),
    .coef_i(coef), .vld_o(vld3), .item_o(item3)
  );

  // Final stage 1: magnitude of the accumulator
  logic        vldf_q;
  evl_t        itemf_q;
  logic [63:0] magf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldf_q <= 1'b0;
    end else if (en) begin
      vldf_q <= vld3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      itemf_q <= item3;
      magf_q  <= item3.acc[63] ? 64'(-item3.acc) : 64'(item3.acc);
    end
  end

  // Final stage 2: round to the output format and saturate; zeroed items give 0
  logic [63:0] rnd;
  logic [31:0] res_d;
  logic        sat_d;
  logic        negf;

  assign negf = itemf_q.acc[63];
  assign rnd  = (magf_q + Half) >> FRAC_BITS;

  always_comb begin
    res_d = negf ? 32'(-rnd[31:0]) : rnd[31:0];
    sat_d = itemf_q.sat;
    if (!negf && (rnd > 64'h0000_0000_7FFF_FFFF)) begin
      res_d = 32'h7FFF_FFFF;
      sat_d = 1'b1;
    end else if (negf && (rnd > 64'h0000_0000_8000_0000)) begin
      res_d = 32'h8000_0000;
      sat_d = 1'b1;
    end
    if (itemf_q.zero) begin
      res_d = '0;
      sat_d = 1'b0;
    end
  end

  logic        out_vld_q;
  logic [31:0] out_res_q;
  logic [1:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vldf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q  <= res_d;
      out_user_q <= {itemf_q.inv, sat_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_res_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- rtl/ccf_derive.sv -----
// Fit sequencer: derives the cubic coefficients with a shared multiplier and divider.
module ccf_derive import ccf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               fit_mode_i,
  input  logic signed [31:0] start_value_i,
  input  logic signed [31:0] start_slope_i,
  input  logic signed [31:0] start_accel_i,
  input  logic signed [31:0] end_value_i,
  input  logic signed [31:0] span_length_i,
  output logic               busy_o,
  output coef_t              coef_o
);

  localparam int unsigned NumW = 65 + FRAC_BITS;
  localparam int unsigned CntW = $clog2(NumW + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_M0_A = 4'd2;
  localparam logic [3:0] ST_M0_B = 4'd3;
  localparam logic [3:0] ST_M0_C = 4'd4;
  localparam logic [3:0] ST_M1_A = 4'd5;
  localparam logic [3:0] ST_M1_B = 4'd6;
  localparam logic [3:0] ST_M1_C = 4'd7;
  localparam logic [3:0] ST_M1_D = 4'd8;
  localparam logic [3:0] ST_D1   = 4'd9;
  localparam logic [3:0] ST_D2   = 4'd10;
  localparam logic [3:0] ST_D3   = 4'd11;
  localparam logic [3:0] ST_POST = 4'd12;

  logic [3:0] state_q, state_d;
  logic       pend_q, pend_d;
  logic       redo_q, redo_d;
  logic signed [63:0] c0_q, c0_d, c1_q, c1_d, c2_q, c2_d, c3_q, c3_d;
  logic signed [63:0] e_q, e_d, n_q, n_d, t_q, t_d;
  logic signed [63:0] c2x2_q, c2x2_d, c3x3_q, c3x3_d, c3x6_q, c3x6_d;
  logic       sat_q, sat_d, s2_q, s2_d, s3_q, s3_d, s6_q, s6_d;

  logic               go, go_div;
  logic signed [63:0] opx;
  logic               op_done, op_sat;
  logic signed [63:0] op_res;

  // Shared multiplier: one 32x32 product per cycle, two partial products
  logic [1:0]  mph_q;
  logic [63:0] mua_q;
  logic [31:0] mub_q;
  logic        mneg_q;
  logic [63:0] tlo_q, thi_q;
  logic [31:0] mop;
  logic [63:0] mprod;
  umag_t       mfin;

  assign mop   = (mph_q == 2'd1) ? mua_q[31:0] : mua_q[63:32];
  assign mprod = mop * mub_q;
  assign mfin  = mulq_fin(tlo_q, thi_q, FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mph_q <= 2'd0;
    end else if (go && !go_div) begin
      mph_q <= 2'd1;
    end else if (mph_q != 2'd0) begin
      mph_q <= mph_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && !go_div) begin
      mua_q  <= opx[63] ? 64'(-opx) : 64'(opx);
      mub_q  <= span_length_i;
      mneg_q <= opx[63];
    end
    if (mph_q == 2'd1) tlo_q <= mprod;
    if (mph_q == 2'd2) thi_q <= mprod;
  end

  // Shared divider: restoring, one quotient bit per cycle
  logic [CntW-1:0] dcnt_q;
  logic [NumW-1:0] dnum_q, dquo_q;
  logic [31:0]     drem_q;
  logic            dneg_q, dbusy_q, ddone_q;
  logic [32:0]     dtrial;
  logic            dge;
  logic [63:0]     dua;
  logic            dsat;

  assign dtrial = {drem_q, dnum_q[NumW-1]};
  assign dge    = dtrial >= {1'b0, span_length_i};
  assign dua    = opx[63] ? 64'(-opx) : 64'(opx);
  assign dsat   = |dquo_q[NumW-1:63];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= 1'b0;
      if (go && go_div) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= CntW'(NumW);
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == CntW'(1)) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && go_div) begin
      dnum_q <= NumW'({dua, {FRAC_BITS{1'b0}}}) + NumW'(span_length_i[31:1]);
      drem_q <= '0;
      dquo_q <= '0;
      dneg_q <= opx[63];
    end else if (dbusy_q) begin
      dnum_q <= {dnum_q[NumW-2:0], 1'b0};
      drem_q <= dge ? 32'(dtrial - {1'b0, span_length_i}) : dtrial[31:0];
      dquo_q <= {dquo_q[NumW-2:0], dge};
    end
  end

  // Result of whichever unit finished
  always_comb begin
    op_done = (mph_q == 2'd3) || ddone_q;
    if (ddone_q) begin
      op_sat = dsat;
      op_res = dsat ? signed_of(64'(S64_MAX), dneg_q) : signed_of({1'b0, dquo_q[62:0]}, dneg_q);
    end else begin
      op_sat = mfin.sat;
      op_res = signed_of(mfin.mag, mneg_q);
    end
  end

  // Fit program sequencer
  always_comb begin
    sval_t       sa;
    sval_t       k2, k3, k6;
    logic signed [67:0] w3;
    state_d = state_q;
    pend_d  = pend_q;
    redo_d  = redo_q;
    c0_d = c0_q; c1_d = c1_q; c2_d = c2_q; c3_d = c3_q;
    e_d = e_q; n_d = n_q; t_d = t_q;
    c2x2_d = c2x2_q; c3x3_d = c3x3_q; c3x6_d = c3x6_q;
    sat_d = sat_q; s2_d = s2_q; s3_d = s3_q; s6_d = s6_q;
    go     = 1'b0;
    go_div = 1'b0;
    opx    = '0;
    sa     = '0;
    w3     = (68'(c3_q) <<< 1) + 68'(c3_q);
    k2     = clamp64(68'(c2_q) <<< 1);
    k3     = clamp64(w3);
    k6     = clamp64(w3 <<< 1);

    // a write during a pass asks for one more pass
    if (start_i && (state_q != ST_IDLE)) redo_d = 1'b1;

    unique case (state_q)
      ST_M0_A: opx = c1_q;
      ST_M0_B: opx = c2_q;
      ST_M0_C: opx = t_q;
      ST_M1_A: opx = e_q + (e_q <<< 1);
      ST_M1_B: opx = t_q;
      ST_M1_C: opx = c1_q <<< 1;
      ST_M1_D: opx = c1_q;
      ST_D1:   opx = n_q;
      ST_D2:   opx = t_q;
      ST_D3:   opx = t_q;
      default: opx = '0;
    endcase
    go_div = (state_q == ST_M1_A) || (state_q == ST_M1_B) || (state_q == ST_M1_C) ||
             (state_q == ST_D1) || (state_q == ST_D2) || (state_q == ST_D3);

    unique case (state_q)
      ST_IDLE: begin
        if (start_i || redo_q) begin
          state_d = ST_INIT;
          redo_d  = 1'b0;
        end
      end
      ST_INIT: begin
        sat_d = 1'b0; s2_d = 1'b0; s3_d = 1'b0; s6_d = 1'b0;
        c0_d = '0; c1_d = '0; c2_d = '0; c3_d = '0;
        c2x2_d = '0; c3x3_d = '0; c3x6_d = '0;
        pend_d = 1'b0;
        if (span_length_i < 32'sd1) begin
          state_d = ST_IDLE;
        end else begin
          c0_d = 64'(start_value_i) <<< FRAC_BITS;
          c1_d = 64'(start_slope_i) <<< FRAC_BITS;
          e_d  = (64'(end_value_i) - 64'(start_value_i)) <<< FRAC_BITS;
          if (!fit_mode_i) begin
            c2_d    = 64'(start_accel_i) <<< (FRAC_BITS - 1);
            state_d = ST_M0_A;
          end else begin
            state_d = ST_M1_A;
          end
        end
      end
      ST_POST: begin
        c2x2_d = k2.val; s2_d = k2.sat;
        c3x3_d = k3.val; s3_d = k3.sat;
        c3x6_d = k6.val; s6_d = k6.sat;
        state_d = ST_IDLE;
      end
      default: begin
        // one shared-unit operation per state
        if (!pend_q) begin
          go     = 1'b1;
          pend_d = 1'b1;
        end else if (op_done) begin
          pend_d = 1'b0;
          sat_d  = sat_q | op_sat;
          unique case (state_q)
            ST_M0_A: begin
              sa = sadd64(e_q, -op_res);
              n_d = sa.val; state_d = ST_M0_B;
            end
            ST_M0_B: begin
              t_d = op_res; state_d = ST_M0_C;
            end
            ST_M0_C: begin
              sa = sadd64(n_q, -op_res);
              n_d = sa.val; state_d = ST_D1;
            end
            ST_M1_A: begin
              t_d = op_res; state_d = ST_M1_B;
            end
            ST_M1_B: begin
              t_d = op_res; state_d = ST_M1_C;
            end
            ST_M1_C: begin
              sa = sadd64(t_q, -op_res);
              c2_d = sa.val; state_d = ST_M1_D;
            end
            ST_M1_D: begin
              sa = sadd64(op_res, -(e_q <<< 1));
              n_d = sa.val; state_d = ST_D1;
            end
            ST_D1: begin
              t_d = op_res; state_d = ST_D2;
            end
            ST_D2: begin
              t_d = op_res; state_d = ST_D3;
            end
            ST_D3: begin
              c3_d = op_res; state_d = ST_POST;
            end
            default: state_d = ST_IDLE;
          endcase
          sat_d = sat_d | sa.sat;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      redo_q  <= 1'b0;
      c0_q <= '0; c1_q <= '0; c2_q <= '0; c3_q <= '0;
      c2x2_q <= '0; c3x3_q <= '0; c3x6_q <= '0;
      sat_q <= 1'b0; s2_q <= 1'b0; s3_q <= 1'b0; s6_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      redo_q  <= redo_d;
      c0_q <= c0_d; c1_q <= c1_d; c2_q <= c2_d; c3_q <= c3_d;
      c2x2_q <= c2x2_d; c3x3_q <= c3x3_d; c3x6_q <= c3x6_d;
      sat_q <= sat_d; s2_q <= s2_d; s3_q <= s3_d; s6_q <= s6_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
    n_q <= n_d;
    t_q <= t_d;
  end

  assign busy_o       = (state_q != ST_IDLE) || redo_q;
  assign coef_o.c0    = c0_q;
  assign coef_o.c1    = c1_q;
  assign coef_o.c2    = c2_q;
  assign coef_o.c3    = c3_q;
  assign coef_o.c2x2  = c2x2_q;
  assign coef_o.c3x3  = c3x3_q;
  assign coef_o.c3x6  = c3x6_q;
  assign coef_o.sat   = sat_q;
  assign coef_o.sat2x = s2_q;
  assign coef_o.sat3x = s3_q;
  assign coef_o.sat6x = s6_q;

endmodule

// ----- rtl/ccf_horner_step.sv -----
// One Horner step (acc * p + addend) as a four-stage pipeline slice.
module ccf_horner_step import ccf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter logic [2:0]  STEP      = 3'd1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  evl_t  item_i,
  input  coef_t coef_i,
  output logic  vld_o,
  output evl_t  item_o
);

  logic        vld_a_q, vld_b_q, vld_c_q, vld_d_q;
  evl_t        item_a_q, item_b_q, item_c_q, item_d_q;
  evl_t        item_d;
  logic [63:0] ua_a_q;
  logic [63:0] tlo_b_q, thi_b_q;
  logic [63:0] mag_c_q;
  logic        msat_c_q;
  umag_t       mfin;
  logic        act;
  logic signed [63:0] addend;
  sval_t       sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  // Stage A: magnitude of the accumulator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_a_q <= item_i;
      ua_a_q   <= item_i.acc[63] ? 64'(-item_i.acc) : 64'(item_i.acc);
    end
  end

  // Stage B: two 32x32 partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_b_q <= item_a_q;
      tlo_b_q  <= ua_a_q[31:0] * item_a_q.pmag;
      thi_b_q  <= ua_a_q[63:32] * item_a_q.pmag;
    end
  end

  // Stage C: rounding and product saturation
  assign mfin = mulq_fin(tlo_b_q, thi_b_q, FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_c_q <= item_b_q;
      mag_c_q  <= mfin.mag;
      msat_c_q <= mfin.sat;
    end
  end

  // Stage D: add the coefficient for this order; idle steps pass the item on
  assign act = (item_c_q.order < STEP);

  always_comb begin
    unique case (item_c_q.order)
      ORD_VALUE: addend = (STEP == 3'd1) ? coef_i.c2 :
                          (STEP == 3'd2) ? coef_i.c1 : coef_i.c0;
      ORD_SLOPE: addend = (STEP == 3'd2) ? coef_i.c2x2 : coef_i.c1;
      ORD_ACCEL: addend = coef_i.c2x2;
      default:   addend = '0;
    endcase
  end

  assign sum = sadd_sm(addend, mag_c_q, item_c_q.acc[63] ^ item_c_q.pneg);

  always_comb begin
    item_d = item_c_q;
    if (act) begin
      item_d.acc = sum.val;
      item_d.sat = item_c_q.sat | msat_c_q | sum.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) item_d_q <= item_d;
  end

  assign vld_o  = vld_d_q;
  assign item_o = item_d_q;

endmodule
